// ----- hw/rtl/idq_pkg.sv -----
// Shared types and codes for the indexed double-ended queue core.
// No dependencies; idq_ctrl and the top level refer to it by scoped names.
package idq_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_READ       = 3'd4,
        MODE_WRITE      = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    // Per-operation outcome handed from the control unit to the result stage
    typedef struct packed {
        status_t status;
        logic    rd_ok;
    } res_t;

    localparam int VALUE_BITS    = 32;
    localparam int POSITION_BITS = 8;

endpackage

// ----- hw/rtl/idq_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/idq_ctrl.sv -----
// Front pointer and element count of the deque; maps each operation to at most
// one RAM access and decides its status. Depends on idq_pkg.
module idq_ctrl #(
    parameter int CAPACITY = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            op_vld,
    input  logic [2:0]                      op_mode,
    input  logic [idq_pkg::POSITION_BITS-1:0] op_pos,
    output logic                            ram_we,
    output logic                            ram_re,
    output logic [$clog2(CAPACITY)-1:0]     ram_addr,
    output logic [$clog2(CAPACITY+1)-1:0]   count_next,
    output idq_pkg::res_t                   res
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > idq_pkg::POSITION_BITS) ? CNT_W : idq_pkg::POSITION_BITS;

    logic [AW-1:0]    front_reg;
    logic [AW-1:0]    front_next;
    logic [CNT_W-1:0] count_reg;

    logic             full;
    logic             empty;
    logic             in_range;
    logic [AW-1:0]    logical;
    logic [AW:0]      slot_sum;
    logic [AW-1:0]    slot;
    logic [AW-1:0]    front_dec;
    logic [AW-1:0]    front_inc;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign in_range = (CMP_W'(op_pos) < CMP_W'(count_reg));

    // Back pushes land at front + count, indexed accesses at front + position
    assign logical  = (idq_pkg::mode_t'(op_mode) == idq_pkg::MODE_PUSH_BACK)
                      ? count_reg[AW-1:0] : AW'(op_pos);
    assign slot_sum = {1'b0, front_reg} + {1'b0, logical};
    assign slot     = (slot_sum >= (AW+1)'(CAPACITY))
                      ? AW'(slot_sum - (AW+1)'(CAPACITY)) : slot_sum[AW-1:0];

    assign front_dec = (front_reg == '0) ? AW'(CAPACITY - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;

    always_comb
    begin
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = slot;
        front_next = front_reg;
        count_next = count_reg;
        res.status = idq_pkg::STAT_OK;
        res.rd_ok  = 1'b0;
        if (op_vld)
        begin
            unique case (idq_pkg::mode_t'(op_mode))
                idq_pkg::MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        res.status = idq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                idq_pkg::MODE_PUSH_FRONT:
                begin
                    ram_addr = front_dec;
                    if (full)
                    begin
                        res.status = idq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                idq_pkg::MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        res.status = idq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                idq_pkg::MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        res.status = idq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                idq_pkg::MODE_READ:
                begin
                    if (!in_range)
                    begin
                        res.status = idq_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        res.rd_ok = 1'b1;
                    end
                end
                idq_pkg::MODE_WRITE:
                begin
                    if (!in_range)
                    begin
                        res.status = idq_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
                default:
                begin
                    // unused codes: no operation
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/indexed_double_ended_queue_core.sv -----
// Top level of the indexed double-ended queue: command register, control
// unit, element RAM and result stage. Depends on idq_pkg, idq_ctrl, idq_ram.
//
//   channel   handshake            payload
//   command   start (busy = 0)     mode, value, position
//   result    done (1 cycle)       read_value, fill_count, status
//
// One word is taken every cycle; busy stays low. A command passes the command
// register, then the RAM read register and the result registers side by side.
// Every operation makes one RAM access at most, so pointer and count updates
// are done by the time the next command reaches the control unit.
// Reset clears pointer, count and strobes; RAM contents stay undefined.
// The receiver cannot stall, so nothing is held back on the result side.
module indexed_double_ended_queue_core #(
    parameter int CAPACITY     = 256,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [2:0]                             mode,
    input  logic signed [idq_pkg::VALUE_BITS-1:0]  value,
    input  logic [idq_pkg::POSITION_BITS-1:0]      position,
    output logic                                   done,
    output logic signed [idq_pkg::VALUE_BITS-1:0]  read_value,
    output logic [$clog2(CAPACITY+1)-1:0]          fill_count,
    output logic [1:0]                             status
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                                  op_vld_reg;
    logic [2:0]                            op_mode_reg;
    logic [idq_pkg::VALUE_BITS-1:0]        op_value_reg;
    logic [idq_pkg::POSITION_BITS-1:0]     op_pos_reg;

    logic                                  ram_we;
    logic                                  ram_re;
    logic [AW-1:0]                         ram_addr;
    logic [ELEMENT_BITS-1:0]               ram_wdata;
    logic [ELEMENT_BITS-1:0]               ram_rdata;
    logic [63:0]                           val_ext;
    logic [63:0]                           rd_ext;
    logic [CNT_W-1:0]                      count_next;
    idq_pkg::res_t                         res;

    logic                                  done_reg;
    logic [CNT_W-1:0]                      fill_reg;
    idq_pkg::res_t                         res_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_vld_reg <= 1'b0;
        end
        else
        begin
            op_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_mode_reg  <= mode;
            op_value_reg <= value;
            op_pos_reg   <= position;
        end
    end

    idq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_vld     (op_vld_reg),
        .op_mode    (op_mode_reg),
        .op_pos     (op_pos_reg),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .count_next (count_next),
        .res        (res)
    );

    // Sign-extend the word to the element width
    assign val_ext   = {{(64 - idq_pkg::VALUE_BITS){op_value_reg[idq_pkg::VALUE_BITS-1]}},
                        op_value_reg};
    assign ram_wdata = val_ext[ELEMENT_BITS-1:0];

    idq_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= op_vld_reg;
            if (op_vld_reg)
            begin
                res_reg <= res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_vld_reg)
        begin
            fill_reg <= count_next;
        end
    end

    // Zero-extend the element and keep its low word
    assign rd_ext     = 64'(ram_rdata);
    assign done       = done_reg;
    assign read_value = res_reg.rd_ok ? rd_ext[idq_pkg::VALUE_BITS-1:0] : '0;
    assign fill_count = fill_reg;
    assign status     = res_reg.status;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without a command two cycles earlier");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fill_count <= CAPACITY))
        else $error("fill count above capacity");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == idq_pkg::STAT_FULL) |-> (fill_count == CAPACITY))
        else $error("push rejected while not full");

    a_empty_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == idq_pkg::STAT_EMPTY) |-> (fill_count == '0))
        else $error("pop refused while not empty");

    a_read_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != idq_pkg::STAT_OK) |-> (read_value == '0))
        else $error("read data on a failed operation");

endmodule
